@@ rtl/core/bba_pkg.sv @@
// Shared constants, types and a helper function of the bitmap block allocator.
// No dependencies; bitmap_block_allocator imports this package, bba_ram does not.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int MAX_BLOCKS   = 16384;
  localparam int WORD_BITS    = 32;
  localparam int BITMAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;

  localparam int INDEX_W = 14;                       // block_index / result_index field
  localparam int COUNT_W = 15;                       // block_count register
  localparam int BIT_W   = $clog2(WORD_BITS);        // bit position inside a word
  localparam int ADDR_W  = $clog2(BITMAP_WORDS);     // bitmap word address
  localparam int PTR_W   = ADDR_W + 1;               // word counter that can hold the depth

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(16384);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    REQ_FIND      = 2'd0,
    REQ_MARK_USED = 2'd1,
    REQ_MARK_FREE = 2'd2,
    REQ_TEST      = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_MODIFY,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic               used;
    logic               oor;
  } result_t;

  // Position of the lowest clear bit of a word; zero when the word is full.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ rtl/core/bba_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bitmap_block_allocator.sv @@
// Mark and test requests pass through ST_MODIFY and ST_RESP; an out-of-range request goes
// straight to ST_RESP; a search scans up to BITMAP_WORDS (512) words in ST_SEARCH. The
// bitmap RAM read port, one word per cycle, sets the search time. One request is in work
// at a time, and the next one can be accepted while the last result waits in the output register.
// Reset: synchronous, active high; a clearing pass then zeroes all BITMAP_WORDS (512) words
// of the bitmap, and no request is accepted until it ends. block_count resets to 16384.
`timescale 1ns / 1ps

module bitmap_block_allocator (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: block_count, written when cfg_wr_en is high.
  input  logic                        cfg_wr_en,
  input  logic [bba_pkg::COUNT_W-1:0] cfg_wr_data,
  // Request stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [13:0] block_index, [15:14] zero
  input  logic [1:0]                  s_axis_tuser,  // [1:0] req_type
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [13:0] result_index, [14] bit_used,
                                                     // [15] zero
  output logic [1:0]                  m_axis_tuser   // [0] found, [1] out_of_range
);

  import bba_pkg::*;

  // Control state.
  state_t              state, state_next;
  logic [COUNT_W-1:0]  block_count;
  logic [ADDR_W-1:0]   clr_ptr, clr_ptr_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic                chk_valid, chk_valid_next;
  logic                out_valid, out_valid_next;

  // Payload state.
  req_type_t           req_type, req_type_next;
  logic [INDEX_W-1:0]  req_index, req_index_next;
  logic [ADDR_W-1:0]   chk_addr, chk_addr_next;
  result_t             res, res_next;
  result_t             out_res;
  logic                out_load;

  // Bitmap RAM port signals.
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  // Count limits. A count above the bitmap size saturates; words_n is the number of
  // bitmap words that hold at least one block below the count.
  logic [COUNT_W-1:0]   eff_count;
  logic [COUNT_W:0]     count_round;
  logic [PTR_W-1:0]     words_n;

  logic [INDEX_W-1:0]   in_index;
  req_type_t            in_type;
  logic                 in_accept;
  logic [INDEX_W-1:0]   hit_index;
  logic                 word_full;
  logic [BIT_W-1:0]     req_bit;

  assign eff_count   = (block_count > COUNT_MAX) ? COUNT_MAX : block_count;
  assign count_round = {1'b0, eff_count} + (COUNT_W + 1)'(WORD_BITS - 1);
  assign words_n     = count_round[BIT_W +: PTR_W];

  assign in_index  = s_axis_tdata[INDEX_W-1:0];
  assign in_type   = req_type_t'(s_axis_tuser);
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign hit_index = {chk_addr, lowest_zero(ram_rdata)};
  assign word_full = (ram_rdata == {WORD_BITS{1'b1}});
  assign req_bit   = req_index[BIT_W-1:0];

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer. The search keeps one read in flight: the word read in one cycle is checked
  // in the next while the following word is already being fetched. Mark requests are a
  // read-modify-write of one word; tests read the word and pick the bit.
  always_comb begin
    state_next     = state;
    clr_ptr_next   = clr_ptr;
    rd_ptr_next    = rd_ptr;
    chk_valid_next = 1'b0;
    chk_addr_next  = chk_addr;
    req_type_next  = req_type;
    req_index_next = req_index;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = req_index[INDEX_W-1 -: ADDR_W];
    ram_wdata      = ram_rdata;
    ram_raddr      = in_index[INDEX_W-1 -: ADDR_W];
    out_load       = 1'b0;

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_ptr;
        ram_wdata = '0;
        clr_ptr_next = clr_ptr + ADDR_W'(1);
        if (clr_ptr == ADDR_W'(BITMAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          req_type_next  = in_type;
          req_index_next = in_index;
          res_next       = '0;
          if (in_type == REQ_FIND) begin
            rd_ptr_next = '0;
            // With no block at all the search ends at once with nothing found.
            state_next  = (words_n == '0) ? ST_RESP : ST_SEARCH;
          end else begin
            res_next.index = in_index;
            if ({1'b0, in_index} >= eff_count) begin
              res_next.oor = 1'b1;
              state_next   = ST_RESP;
            end else begin
              state_next = ST_MODIFY;
            end
          end
        end
      end

      ST_SEARCH: begin
        ram_raddr = rd_ptr[ADDR_W-1:0];
        if (chk_valid && !word_full) begin
          // First word with a clear bit: the hit counts only if it lies below the count.
          if ({1'b0, hit_index} < eff_count) begin
            res_next.found = 1'b1;
            res_next.index = hit_index;
          end
          state_next = ST_RESP;
        end else if (chk_valid && ((PTR_W'(chk_addr) + PTR_W'(1)) == words_n)) begin
          state_next = ST_RESP;
        end else if (rd_ptr < words_n) begin
          chk_valid_next = 1'b1;
          chk_addr_next  = rd_ptr[ADDR_W-1:0];
          rd_ptr_next    = rd_ptr + PTR_W'(1);
        end
      end

      ST_MODIFY: begin
        if (req_type == REQ_TEST) begin
          res_next.used = ram_rdata[req_bit];
        end else begin
          ram_we             = 1'b1;
          ram_wdata[req_bit] = (req_type == REQ_MARK_USED);
        end
        state_next = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      block_count <= COUNT_RESET;
      clr_ptr     <= '0;
      rd_ptr      <= '0;
      chk_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      clr_ptr   <= clr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      chk_valid <= chk_valid_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        block_count <= cfg_wr_data;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    req_type  <= req_type_next;
    req_index <= req_index_next;
    chk_addr  <= chk_addr_next;
    res       <= res_next;
    if (out_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.used, out_res.index};
  assign m_axis_tuser  = {out_res.oor, out_res.found};

  // A search never reports a range error, and a found block lies below the count.
  a_found_not_oor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and out_of_range both set");

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> ({1'b0, m_axis_tdata[INDEX_W-1:0]} < eff_count))
    else $error("found block not below the block count");

  a_used_not_oor: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[INDEX_W]) |-> !m_axis_tuser[1])
    else $error("bit_used reported for an out-of-range index");

  // The bitmap is written only by the clearing pass and by a mark request.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || (state == ST_MODIFY && req_type != REQ_TEST)))
    else $error("bitmap written outside clear or mark");

endmodule
